// ===== sv/alfp_pkg.sv =====
// shared types and constants for the array linked list with free pool
package alfp_pkg;

    localparam int DEF_LIST_DEPTH = 64;
    localparam int VALUE_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_WALK   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic       load_req;
        logic       ins_start;
        logic       ins_take;
        logic       ins_step;
        logic       scan_start;
        logic       del_step;
        logic       del_free;
        logic       walk_emit;
        logic       resp;
        logic       resp_zero;
        logic [1:0] resp_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       head_null;
        logic       free_null;
        logic       link_null;
        logic       val_match;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/alfp_ram.sv =====
// generic single write port ram with registered read
module alfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/alfp_dp.sv =====
// datapath: node stores, list and free heads, traversal pointers, result register
module alfp_dp #(
    parameter int LIST_DEPTH = alfp_pkg::DEF_LIST_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  alfp_pkg::dp_cmd_t                    cmd,
    output alfp_pkg::dp_stat_t                   stat,
    input  logic [1:0]                           op,
    input  logic signed [alfp_pkg::VALUE_W-1:0]  value,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [1:0]                           status,
    output logic signed [alfp_pkg::VALUE_W-1:0]  item_value,
    output logic                                 last
);

    import alfp_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int LINK_W = $clog2(LIST_DEPTH + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(LIST_DEPTH);

    logic [1:0]         op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [LINK_W-1:0]  list_head_reg, list_head_next;
    logic [LINK_W-1:0]  free_head_reg, free_head_next;
    logic [LINK_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]  prev_reg, prev_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic               res_valid_reg, res_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] item_value_reg, item_value_next;
    logic               last_reg, last_next;

    logic               lwe;
    logic [IDX_W-1:0]   lwaddr;
    logic [LINK_W-1:0]  lwdata;
    logic               vwe;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic [LINK_W-1:0]  link_rd;
    logic [VALUE_W-1:0] value_rd;
    logic               link_null;
    logic               slot_fresh;
    logic [LINK_W-1:0]  slot_plus;
    logic               emit;

    alfp_ram #(.WIDTH(LINK_W), .DEPTH(LIST_DEPTH)) u_link_ram (
        .clk   (clk),
        .we    (lwe),
        .waddr (lwaddr),
        .wdata (lwdata),
        .re    (re),
        .raddr (raddr),
        .rdata (link_rd)
    );

    alfp_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (vwe),
        .waddr (slot_reg),
        .wdata (val_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (value_rd)
    );

    assign link_null = (link_rd >= NULL_LINK);
    // slots at or above the fill count were never taken and still chain to the next slot
    assign slot_fresh = (LINK_W'(slot_reg) >= fill_reg);
    assign slot_plus = LINK_W'(slot_reg) + LINK_W'(1);

    assign stat.op = op_reg;
    assign stat.head_null = (list_head_reg >= NULL_LINK);
    assign stat.free_null = (free_head_reg >= NULL_LINK);
    assign stat.link_null = link_null;
    assign stat.val_match = (value_rd == val_reg);
    assign stat.out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        op_next = op_reg;
        val_next = val_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        fill_next = fill_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        slot_next = slot_reg;
        status_next = status_reg;
        item_value_next = item_value_reg;
        last_next = last_reg;
        emit = 1'b0;
        lwe = 1'b0;
        lwaddr = cur_reg;
        lwdata = NULL_LINK;
        vwe = 1'b0;
        re = 1'b0;
        raddr = cur_reg;

        if (cmd.load_req)
        begin
            op_next = op;
            val_next = value;
        end

        if (cmd.ins_start)
        begin
            slot_next = free_head_reg[IDX_W-1:0];
            re = 1'b1;
            raddr = free_head_reg[IDX_W-1:0];
        end

        if (cmd.ins_take)
        begin
            free_head_next = slot_fresh ? slot_plus : link_rd;
            if (slot_fresh)
            begin
                fill_next = fill_reg + LINK_W'(1);
            end
            vwe = 1'b1;
            lwe = 1'b1;
            lwaddr = slot_reg;
            lwdata = NULL_LINK;
            if (stat.head_null)
            begin
                list_head_next = LINK_W'(slot_reg);
            end
            else
            begin
                cur_next = list_head_reg[IDX_W-1:0];
                re = 1'b1;
                raddr = list_head_reg[IDX_W-1:0];
            end
        end

        if (cmd.ins_step)
        begin
            if (link_null)
            begin
                lwe = 1'b1;
                lwaddr = cur_reg;
                lwdata = LINK_W'(slot_reg);
            end
            else
            begin
                cur_next = link_rd[IDX_W-1:0];
                re = 1'b1;
                raddr = link_rd[IDX_W-1:0];
            end
        end

        if (cmd.scan_start)
        begin
            cur_next = list_head_reg[IDX_W-1:0];
            prev_next = NULL_LINK;
            re = 1'b1;
            raddr = list_head_reg[IDX_W-1:0];
        end

        if (cmd.del_step)
        begin
            if (stat.val_match)
            begin
                if (prev_reg < NULL_LINK)
                begin
                    lwe = 1'b1;
                    lwaddr = prev_reg[IDX_W-1:0];
                    lwdata = link_rd;
                end
                else
                begin
                    list_head_next = link_rd;
                end
            end
            else if (!link_null)
            begin
                prev_next = LINK_W'(cur_reg);
                cur_next = link_rd[IDX_W-1:0];
                re = 1'b1;
                raddr = link_rd[IDX_W-1:0];
            end
        end

        if (cmd.del_free)
        begin
            lwe = 1'b1;
            lwaddr = cur_reg;
            lwdata = free_head_reg;
            free_head_next = LINK_W'(cur_reg);
        end

        if (cmd.walk_emit)
        begin
            emit = 1'b1;
            status_next = ST_OK;
            item_value_next = value_rd;
            last_next = link_null;
            if (!link_null)
            begin
                cur_next = link_rd[IDX_W-1:0];
                re = 1'b1;
                raddr = link_rd[IDX_W-1:0];
            end
        end

        if (cmd.resp)
        begin
            emit = 1'b1;
            status_next = cmd.resp_status;
            item_value_next = cmd.resp_zero ? '0 : val_reg;
            last_next = 1'b1;
        end

        res_valid_next = emit ? 1'b1 : (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head_reg <= NULL_LINK;
            free_head_reg <= '0;
            fill_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            fill_reg <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        val_reg <= val_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        slot_reg <= slot_next;
        status_reg <= status_next;
        item_value_reg <= item_value_next;
        last_reg <= last_next;
    end

    assign res_valid = res_valid_reg;
    assign status = status_reg;
    assign item_value = item_value_reg;
    assign last = last_reg;

endmodule

// ===== sv/alfp_ctrl.sv =====
// controller state machine sequencing insert, delete and walk
module alfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  alfp_pkg::dp_stat_t stat,
    output alfp_pkg::dp_cmd_t  cmd
);

    import alfp_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_INS_FREE = 3'd2;
    localparam logic [2:0] S_INS_WALK = 3'd3;
    localparam logic [2:0] S_DEL_SCAN = 3'd4;
    localparam logic [2:0] S_DEL_FREE = 3'd5;
    localparam logic [2:0] S_WALK     = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] rstat_reg, rstat_next;
    logic       rzero_reg, rzero_next;

    always_comb
    begin
        state_next = state_reg;
        rstat_next = rstat_reg;
        rzero_next = rzero_reg;
        cmd = '0;
        cmd.resp_status = rstat_reg;
        cmd.resp_zero = rzero_reg;
        req_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                rzero_next = 1'b0;
                rstat_next = ST_OK;
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.free_null)
                        begin
                            rstat_next = ST_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next = S_INS_FREE;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.head_null)
                        begin
                            rstat_next = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = S_DEL_SCAN;
                        end
                    end
                    OP_WALK:
                    begin
                        if (stat.head_null)
                        begin
                            rstat_next = ST_EMPTY;
                            rzero_next = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_FREE:
            begin
                cmd.ins_take = 1'b1;
                state_next = stat.head_null ? S_RESP : S_INS_WALK;
            end
            S_INS_WALK:
            begin
                cmd.ins_step = 1'b1;
                if (stat.link_null)
                begin
                    state_next = S_RESP;
                end
            end
            S_DEL_SCAN:
            begin
                cmd.del_step = 1'b1;
                if (stat.val_match)
                begin
                    state_next = S_DEL_FREE;
                end
                else if (stat.link_null)
                begin
                    rstat_next = ST_NOTFOUND;
                    state_next = S_RESP;
                end
            end
            S_DEL_FREE:
            begin
                cmd.del_free = 1'b1;
                state_next = S_RESP;
            end
            S_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.walk_emit = 1'b1;
                    if (stat.link_null)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.resp = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rstat_reg <= ST_OK;
            rzero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rstat_reg <= rstat_next;
            rzero_reg <= rzero_next;
        end
    end

endmodule

// ===== sv/array_linked_list_free_pool_top.sv =====
// insert: dispatch, take a free slot, link it at the tail, respond; output stalls delay results
// delete: dispatch, scan to the match, free its slot, respond; absent or empty: respond
// walk: dispatch, then emit node by node; each traversal step is one registered read
// one request in flight at a time; the next is taken while the last result waits in the output
// reset (async, active low) empties the list and starts the free chain at slot zero
// the link store needs no clearing pass: a fill count marks slots never taken yet
module array_linked_list_free_pool_top #(
    parameter int LIST_DEPTH = alfp_pkg::DEF_LIST_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           op,
    input  logic signed [alfp_pkg::VALUE_W-1:0]  value,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [1:0]                           status,
    output logic signed [alfp_pkg::VALUE_W-1:0]  item_value,
    output logic                                 last
);

    import alfp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    alfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    alfp_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .value      (value),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .status     (status),
        .item_value (item_value),
        .last       (last)
    );

endmodule
